@@ src/nvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvm_pkg
// Shared types and constants of the nibble VM execute unit.
// ----------------------------------------------------------------------------
package nvm_pkg;

  // default geometry (MEM_BYTES is a power of two)
  localparam int MEM_BYTES_DEF     = 4096;
  localparam int VRAM_BASE_DEF     = 3072;
  localparam int DISPLAY_BYTES_DEF = 1024;
  localparam int ROW_PIXELS_DEF    = 64;

  // register file
  localparam int REG_AW = 4;
  localparam int REG_W  = 8;
  localparam int REG_NUM = 16;

  // stream words
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int WADDR_W     = 12;

  localparam logic [REG_AW-1:0] FLAG_REG = 4'hF;
  localparam logic [REG_W-1:0]  FLAG_EQ  = 8'd8;
  localparam logic [REG_W-1:0]  FLAG_NE  = 8'd4;

  // jump conditions
  localparam logic [3:0] JUMP_IF_EQ = 4'd1;
  localparam logic [3:0] JUMP_IF_NE = 4'd2;

  typedef enum logic [3:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_INDEX   = 4'd2,
    ACT_LOAD    = 4'd3,
    ACT_STORE   = 4'd4,
    ACT_CLEAR   = 4'd5,
    ACT_PIXEL   = 4'd6,
    ACT_COMPARE = 4'd7,
    ACT_JUMP    = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_PIXEL,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [REG_W-1:0]  data;
  } rf_wr_t;

endpackage
`default_nettype wire

@@ src/nibble_vm_execute_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_vm_execute_unit
// Executes one decoded instruction of the nibble VM per input word.
// ----------------------------------------------------------------------------
// Flow: accept reads the register file; ST_EXEC executes and loads the result
//   word register, except for pixel, which adds ST_PIXEL for a byte memory
//   read, and clear, which adds ST_CLEAR and sweeps one byte per cycle.
// A new word is taken only in ST_IDLE, with the output slot free or draining.
// Reset: control cleared at once, then a clearing pass over all MEM_BYTES
//   bytes of the byte memory with s_axis_tready_o low.
// ----------------------------------------------------------------------------
module nibble_vm_execute_unit import nvm_pkg::*; #(
  parameter int MEM_BYTES     = MEM_BYTES_DEF,     // power of two
  parameter int VRAM_BASE     = VRAM_BASE_DEF,
  parameter int DISPLAY_BYTES = DISPLAY_BYTES_DEF,
  parameter int ROW_PIXELS    = ROW_PIXELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // action[3:0], arg_a[7:4], arg_b[11:8], arg_c[15:12]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // program_counter[7:0], index_value[23:8], write_address[35:24],
  // write_data[43:36], zero pad[47:44]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // memory_written[0]
  output logic                   m_axis_tuser_o
);

  localparam int MemAw    = $clog2(MEM_BYTES);
  localparam int SweepMax = (MEM_BYTES > DISPLAY_BYTES) ? MEM_BYTES : DISPLAY_BYTES;
  localparam int CntW     = $clog2(SweepMax);
  localparam logic [MemAw-1:0] VramBase  = MemAw'(VRAM_BASE);
  localparam logic [CntW-1:0]  InitLast  = CntW'(MEM_BYTES - 1);
  localparam logic [CntW-1:0]  ClearLast = CntW'(DISPLAY_BYTES - 1);
  localparam logic [16:0]      RowPix    = 17'(ROW_PIXELS);

  // --------------------------------------------------------------------------
  // input word fields
  // --------------------------------------------------------------------------
  action_e    in_action;
  logic [3:0] in_a, in_b, in_c;

  assign in_action = action_e'(s_axis_tdata_i[3:0]);
  assign in_a      = s_axis_tdata_i[7:4];
  assign in_b      = s_axis_tdata_i[11:8];
  assign in_c      = s_axis_tdata_i[15:12];

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]    index_q, index_d;
  logic [7:0]     pc_q, pc_d;
  logic           out_valid_q, out_valid_d;

  // instruction held through execute
  action_e    act_q;
  logic [3:0] a_q, b_q, c_q;

  // pixel read-modify-write context
  logic [MemAw-1:0] pix_addr_q, pix_addr;
  logic             pix_odd_q;

  // output word
  logic [7:0]         out_pc_q;
  logic [15:0]        out_index_q;
  logic               out_wr_q, out_wr;
  logic [WADDR_W-1:0] out_waddr_q, out_waddr;
  logic [7:0]         out_wdata_q, out_wdata;
  logic               out_load;

  logic accept;

  // --------------------------------------------------------------------------
  // register file: read at accept, data valid during ST_EXEC
  // --------------------------------------------------------------------------
  logic [REG_AW-1:0] rf_rd_a_addr;
  logic [REG_W-1:0]  rf_a, rf_b;
  rf_wr_t            rf_wr;

  // jump tests the flag register through port A
  assign rf_rd_a_addr = (in_action == ACT_JUMP) ? FLAG_REG : in_b;

  nvm_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_addr_i (rf_rd_a_addr),
    .rd_b_addr_i (in_c),
    .wr_i        (rf_wr),
    .rd_a_data_o (rf_a),
    .rd_b_data_o (rf_b)
  );

  // --------------------------------------------------------------------------
  // byte memory
  // --------------------------------------------------------------------------
  logic             mem_we;
  logic [MemAw-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;

  nvm_bytemem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_bytemem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (pix_addr),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // address arithmetic; all addresses wrap by truncation
  // --------------------------------------------------------------------------
  logic [16:0]      pix_off;
  logic [16:0]      st_sum;
  logic [MemAw-1:0] st_addr;
  logic [MemAw-1:0] sweep_addr;
  logic [16:0]      st_addr_x, pix_addr_x;

  // byte of pixel (x, y): two pixels per byte, even x in the high nibble
  assign pix_off  = (17'(rf_a) + 17'(rf_b) * RowPix) >> 1;
  assign pix_addr = VramBase + pix_off[MemAw-1:0];

  assign st_sum  = 17'(index_q) + 17'(a_q);
  assign st_addr = st_sum[MemAw-1:0];

  assign sweep_addr = (state_q == ST_INIT) ? cnt_q[MemAw-1:0]
                                           : VramBase + cnt_q[MemAw-1:0];

  assign st_addr_x  = 17'(st_addr);
  assign pix_addr_x = 17'(pix_addr_q);

  // --------------------------------------------------------------------------
  // handshake: one instruction in flight, output slot free on entry
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_INIT: begin
        if (cnt_q == InitLast) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (act_q == ACT_PIXEL) begin
          state_d = ST_PIXEL;
        end else if (act_q == ACT_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PIXEL: begin
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (cnt_q == ClearLast) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // execute: register file and memory writes, result word
  // --------------------------------------------------------------------------
  always_comb begin
    rf_wr     = '0;
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    index_d   = index_q;
    pc_d      = pc_q;
    out_load  = 1'b0;
    out_wr    = 1'b0;
    out_waddr = '0;
    out_wdata = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
      end
      ST_EXEC: begin
        out_load = (act_q != ACT_PIXEL) && (act_q != ACT_CLEAR);
        unique case (act_q)
          ACT_ADD: begin
            rf_wr     = '{en: 1'b1, addr: a_q, data: rf_a + rf_b};
            out_wdata = rf_a + rf_b;
          end
          ACT_SUB: begin
            rf_wr     = '{en: 1'b1, addr: a_q, data: rf_a - rf_b};
            out_wdata = rf_a - rf_b;
          end
          ACT_INDEX: begin
            index_d = {a_q, b_q, 4'h0, c_q};
          end
          ACT_LOAD: begin
            rf_wr     = '{en: 1'b1, addr: a_q, data: {b_q, c_q}};
            out_wdata = {b_q, c_q};
          end
          ACT_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = st_addr;
            mem_wdata = {b_q, c_q};
            out_wr    = 1'b1;
            out_waddr = st_addr_x[WADDR_W-1:0];
            out_wdata = {b_q, c_q};
          end
          ACT_CLEAR: begin
          end
          ACT_PIXEL: begin
          end
          ACT_COMPARE: begin
            rf_wr     = '{en: 1'b1, addr: FLAG_REG,
                          data: (rf_a == rf_b) ? FLAG_EQ : FLAG_NE};
            out_wdata = (rf_a == rf_b) ? FLAG_EQ : FLAG_NE;
          end
          ACT_JUMP: begin
            // rf_a holds the flag register here
            if (a_q == JUMP_IF_EQ) begin
              if (rf_a == FLAG_EQ) pc_d = {b_q, c_q};
            end else if (a_q == JUMP_IF_NE) begin
              if (rf_a == FLAG_NE) pc_d = {b_q, c_q};
            end else begin
              pc_d = {b_q, c_q};
            end
          end
          default: begin
          end
        endcase
      end
      ST_PIXEL: begin
        mem_we    = 1'b1;
        mem_waddr = pix_addr_q;
        mem_wdata = mem_rdata | (pix_odd_q ? {4'h0, a_q} : {a_q, 4'h0});
        out_load  = 1'b1;
        out_wr    = 1'b1;
        out_waddr = pix_addr_x[WADDR_W-1:0];
        out_wdata = mem_rdata | (pix_odd_q ? {4'h0, a_q} : {a_q, 4'h0});
      end
      ST_CLEAR: begin
        mem_we   = 1'b1;
        out_load = (cnt_q == ClearLast);
      end
      default: begin
      end
    endcase
  end

  // output slot: filled only when empty (guaranteed by the accept rule)
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !m_axis_tready_i);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      index_q     <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      index_q     <= index_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_action;
      a_q   <= in_a;
      b_q   <= in_b;
      c_q   <= in_c;
    end
    if (state_q == ST_EXEC) begin
      pix_addr_q <= pix_addr;
      pix_odd_q  <= rf_a[0];
    end
    if (out_load) begin
      out_pc_q    <= pc_d;
      out_index_q <= index_d;
      out_wr_q    <= out_wr;
      out_waddr_q <= out_waddr;
      out_wdata_q <= out_wdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_wdata_q, out_waddr_q, out_index_q, out_pc_q};
  assign m_axis_tuser_o  = out_wr_q;

endmodule
`default_nettype wire

@@ src/nvm_regfile.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvm_regfile
// 16 x 8 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module nvm_regfile import nvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [REG_AW-1:0] rd_a_addr_i,
  input  logic [REG_AW-1:0] rd_b_addr_i,
  input  rf_wr_t            wr_i,
  output logic [REG_W-1:0]  rd_a_data_o,
  output logic [REG_W-1:0]  rd_b_data_o
);

  logic [REG_W-1:0]   mem_q [REG_NUM];
  logic [REG_NUM-1:0] valid_q;
  logic [REG_W-1:0]   rd_a_q;
  logic [REG_W-1:0]   rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= valid_q[rd_a_addr_i] ? mem_q[rd_a_addr_i] : '0;
    rd_b_q <= valid_q[rd_b_addr_i] ? mem_q[rd_b_addr_i] : '0;
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule
`default_nettype wire

@@ src/nvm_bytemem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvm_bytemem
// Byte memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module nvm_bytemem import nvm_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  localparam int MemAw    = $clog2(MEM_BYTES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [MemAw-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [MemAw-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [MEM_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/nvm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvm_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module nvm_checker import nvm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tuser_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // one instruction in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  // no result in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("result appeared one cycle after accept");

  // no new instruction while a result is stuck
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input ready while result is stalled");

endmodule

bind nibble_vm_execute_unit nvm_checker u_nvm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

@@ test/nibble_vm_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_vm_execute_unit_tb
// Self-checking bench for the nibble VM execute unit. Instructions stream in
// through a queue-fed driver. A built-in copy of the machine state (registers,
// index, program counter, byte memory) predicts each result word, and a
// monitor compares result words field by field in arrival order. A directed
// block covers wraps, flags, jumps, pixel nibbles, clear and unused codes.
// About two thousand random instructions follow, under changing
// back-pressure.
// ----------------------------------------------------------------------------
module nibble_vm_execute_unit_tb;
  import nvm_pkg::*;

  localparam int N_RANDOM      = 2000;
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int HOLD_AFTER    = 150;  // words accepted before the hold-off
  localparam int DRAIN_CYCLES  = 16;

  // expected result word, fields in output order
  typedef struct packed {
    logic [7:0]         pc;
    logic [15:0]        idx;
    logic               wr;
    logic [WADDR_W-1:0] waddr;
    logic [7:0]         wdata;
  } vm_result_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tready_i = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  nibble_vm_execute_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // machine state as the bench sees it
  logic [REG_W-1:0] gpr [REG_NUM];
  logic [15:0]      idx_q;
  logic [7:0]       pc_q;
  logic [7:0]       vmem [MEM_BYTES_DEF];

  logic [IN_TDATA_W-1:0] insn_queue [$];
  vm_result_t            expected_results [$];

  bit feeding    = 1'b0;
  bit word_taken = 1'b0;
  bit held_once  = 1'b0;
  int hold_left  = 0;
  int n_insn_total = 0;
  int n_insn_in    = 0;
  int n_checked    = 0;
  int n_err        = 0;
  int n_jump_taken = 0;
  int act_seen [16];

  function automatic logic [IN_TDATA_W-1:0] insn(input logic [3:0] act,
                                                 input logic [3:0] a,
                                                 input logic [3:0] b,
                                                 input logic [3:0] c);
    return {c, b, a, act};
  endfunction

  // Runs one instruction against the bench's machine state.
  function automatic vm_result_t execute_insn(input logic [IN_TDATA_W-1:0] word);
    logic [3:0] act, a, b, c;
    logic [7:0] x, y;
    logic       take;
    int         addr;
    vm_result_t r;
    act = word[3:0];
    a   = word[7:4];
    b   = word[11:8];
    c   = word[15:12];
    r   = '0;
    case (act)
      ACT_ADD: begin
        gpr[a]  = gpr[b] + gpr[c];
        r.wdata = gpr[a];
      end
      ACT_SUB: begin
        gpr[a]  = gpr[b] - gpr[c];
        r.wdata = gpr[a];
      end
      ACT_INDEX: idx_q = {a, b, 4'h0, c};
      ACT_LOAD: begin
        gpr[a]  = {b, c};
        r.wdata = gpr[a];
      end
      ACT_STORE: begin
        addr       = (int'(idx_q) + int'(a)) % MEM_BYTES_DEF;
        vmem[addr] = {b, c};
        r.wr       = 1'b1;
        r.waddr    = WADDR_W'(addr);
        r.wdata    = vmem[addr];
      end
      ACT_CLEAR: begin
        for (int i = 0; i < DISPLAY_BYTES_DEF; i++)
          vmem[(VRAM_BASE_DEF + i) % MEM_BYTES_DEF] = 8'h00;
      end
      ACT_PIXEL: begin
        x    = gpr[b];
        y    = gpr[c];
        addr = (VRAM_BASE_DEF + (int'(x) + int'(y) * ROW_PIXELS_DEF) / 2) % MEM_BYTES_DEF;
        // even x owns the high nibble, odd x the low one
        if (!x[0]) vmem[addr] = vmem[addr] | {a, 4'h0};
        else       vmem[addr] = vmem[addr] | {4'h0, a};
        r.wr    = 1'b1;
        r.waddr = WADDR_W'(addr);
        r.wdata = vmem[addr];
      end
      ACT_COMPARE: begin
        gpr[FLAG_REG] = (gpr[b] == gpr[c]) ? FLAG_EQ : FLAG_NE;
        r.wdata       = gpr[FLAG_REG];
      end
      ACT_JUMP: begin
        if (a == JUMP_IF_EQ)      take = (gpr[FLAG_REG] == FLAG_EQ);
        else if (a == JUMP_IF_NE) take = (gpr[FLAG_REG] == FLAG_NE);
        else                      take = 1'b1;
        if (take) begin
          pc_q = {b, c};
          n_jump_taken++;
        end
      end
      default: ;  // unused codes leave the state alone
    endcase
    r.pc  = pc_q;
    r.idx = idx_q;
    return r;
  endfunction

  // sender idles less often than the receiver stalls in phase 0, more often in phase 1; neither idles in phase 2
  function automatic int idle_pct(input bit is_sender);
    if (n_insn_in < n_insn_total / 3)          return is_sender ? 32 : 45;
    else if (n_insn_in < 2 * n_insn_total / 3) return is_sender ? 45 : 32;
    else                                       return 0;
  endfunction

  task automatic report_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, what, want, got);
    end
  endtask

  task automatic check_result(input vm_result_t got);
    vm_result_t want;
    if (expected_results.size() == 0) begin
      n_err++;
      $display("%0t ns: result word with nothing pending, got 0x%0h",
               $time, got);
    end else begin
      want = expected_results.pop_front();
      report_field("program_counter", 16'(want.pc),    16'(got.pc));
      report_field("index_value",     want.idx,        got.idx);
      report_field("memory_written",  16'(want.wr),    16'(got.wr));
      report_field("write_address",   16'(want.waddr), 16'(got.waddr));
      report_field("write_data",      16'(want.wdata), 16'(got.wdata));
    end
    n_checked++;
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (word_taken) begin
        expected_results.push_back(execute_insn(s_axis_tdata_i));
        act_seen[s_axis_tdata_i[3:0]]++;
        n_insn_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i)
        check_result({m_axis_tdata_o[7:0], m_axis_tdata_o[23:8], m_axis_tuser_o,
                      m_axis_tdata_o[35:24], m_axis_tdata_o[43:36]});
    end
  end

  // Driver: a word is held until taken, then the next one or an idle cycle.
  always @(negedge clk_i) begin
    if (feeding && (!s_axis_tvalid_i || word_taken)) begin
      if (insn_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        s_axis_tdata_i  <= insn_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk_i) begin
    if (!feeding) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!held_once && n_insn_in >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  initial begin
    logic [3:0] act, a, b, c;
    int         sel;
    for (int i = 0; i < REG_NUM; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_BYTES_DEF; i++) vmem[i] = '0;
    for (int i = 0; i < 16; i++) act_seen[i] = 0;
    idx_q = '0;
    pc_q  = '0;

    // directed: wraps, flags and jumps, nibble merge, clear, unused codes
    insn_queue.push_back(insn(ACT_LOAD,    4'd1, 4'hF, 4'hF));
    insn_queue.push_back(insn(ACT_LOAD,    4'd2, 4'h0, 4'h1));
    insn_queue.push_back(insn(ACT_ADD,     4'd3, 4'd1, 4'd2));   // 0xFF + 1 wraps
    insn_queue.push_back(insn(ACT_SUB,     4'd4, 4'd3, 4'd2));   // 0 - 1 wraps
    insn_queue.push_back(insn(ACT_ADD,     4'd0, 4'd1, 4'd1));
    insn_queue.push_back(insn(ACT_INDEX,   4'hF, 4'hF, 4'hF));
    insn_queue.push_back(insn(ACT_STORE,   4'hF, 4'hA, 4'h5));   // address wraps
    insn_queue.push_back(insn(ACT_INDEX,   4'h0, 4'h0, 4'h0));
    insn_queue.push_back(insn(ACT_STORE,   4'h0, 4'h0, 4'h0));
    insn_queue.push_back(insn(ACT_COMPARE, 4'h0, 4'd1, 4'd4));   // equal
    insn_queue.push_back(insn(ACT_JUMP,    JUMP_IF_EQ, 4'hF, 4'hF));
    insn_queue.push_back(insn(ACT_JUMP,    JUMP_IF_NE, 4'h1, 4'h2));
    insn_queue.push_back(insn(ACT_COMPARE, 4'h0, 4'd1, 4'd2));   // not equal
    insn_queue.push_back(insn(ACT_JUMP,    JUMP_IF_EQ, 4'h3, 4'h4));
    insn_queue.push_back(insn(ACT_JUMP,    JUMP_IF_NE, 4'h0, 4'h0));
    insn_queue.push_back(insn(ACT_JUMP,    4'hF, 4'hA, 4'hB));   // unconditional
    insn_queue.push_back(insn(ACT_LOAD,    4'd5, 4'h0, 4'h0));
    insn_queue.push_back(insn(ACT_LOAD,    4'd6, 4'hF, 4'hF));
    insn_queue.push_back(insn(ACT_PIXEL,   4'hF, 4'd1, 4'd1));   // odd x, far y
    insn_queue.push_back(insn(ACT_PIXEL,   4'hF, 4'd5, 4'd6));   // even x, far y
    insn_queue.push_back(insn(ACT_PIXEL,   4'h3, 4'd5, 4'd5));   // high nibble at base
    insn_queue.push_back(insn(ACT_LOAD,    4'd7, 4'h0, 4'h1));
    insn_queue.push_back(insn(ACT_PIXEL,   4'hC, 4'd7, 4'd5));   // low nibble, same byte
    insn_queue.push_back(insn(ACT_CLEAR,   4'h0, 4'h0, 4'h0));
    insn_queue.push_back(insn(ACT_PIXEL,   4'h0, 4'd5, 4'd5));   // reads cleared byte
    insn_queue.push_back(insn(4'(ACT_JUMP) + 4'd1, 4'hF, 4'hF, 4'hF));
    insn_queue.push_back(insn(4'(ACT_JUMP) + 4'd7, 4'h5, 4'hA, 4'h5));

    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 199);
      a   = 4'($urandom);
      b   = 4'($urandom);
      c   = 4'($urandom);
      if (sel == 0)       act = ACT_CLEAR;  // rare, it sweeps the whole display
      else if (sel <= 6)  act = 4'(ACT_JUMP) + 4'($urandom_range(1, 7));
      else if (sel < 56)  act = ACT_LOAD;
      else if (sel < 86)  act = $urandom_range(0, 1) ? ACT_ADD : ACT_SUB;
      else if (sel < 102) act = ACT_INDEX;
      else if (sel < 126) act = ACT_STORE;
      else if (sel < 156) act = ACT_PIXEL;
      else if (sel < 176) begin
        act = ACT_COMPARE;
        if ($urandom_range(0, 3) == 0) c = b;
      end else begin
        act = ACT_JUMP;
        if ($urandom_range(0, 3) != 0) a = $urandom_range(0, 1) ? JUMP_IF_EQ : JUMP_IF_NE;
      end
      insn_queue.push_back(insn(act, a, b, c));
    end
    n_insn_total = insn_queue.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    feeding = 1'b1;

    while (n_insn_in < n_insn_total || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Executed %0d instructions: %0d pixel, %0d store, %0d clear, %0d jumps taken",
             n_insn_in, act_seen[ACT_PIXEL], act_seen[ACT_STORE], act_seen[ACT_CLEAR],
             n_jump_taken);
    $display("Checked %0d result words, %0d field mismatches", n_checked, n_err);
    if (n_err == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Timeout after %0d of %0d instructions", n_insn_in, n_insn_total);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/nvm_pkg.sv
src/nvm_regfile.sv
src/nvm_bytemem.sv
src/nibble_vm_execute_unit.sv
src/nvm_checker.sv
test/nibble_vm_execute_unit_tb.sv
